FILE: design/amst_pkg.sv
// Shared types, codes and constants of the affine matrix stack transform.
package amst_pkg;

  localparam int STACK_LEVELS_DEF = 32;
  localparam int COEF_W           = 32;
  localparam int COORD_W          = 16;
  localparam int MAT_WORDS        = 6;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 16;

  localparam logic [2:0] KIND_PUSH   = 3'd0;
  localparam logic [2:0] KIND_POP    = 3'd1;
  localparam logic [2:0] KIND_MUL    = 3'd2;
  localparam logic [2:0] KIND_BEGIN  = 3'd3;
  localparam logic [2:0] KIND_VERTEX = 3'd4;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_APPENDED  = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'b1;

  localparam logic [COEF_W-1:0] Q16_ONE = 32'h0001_0000;

  // word order: a, b, c, d, tx, ty
  typedef logic [MAT_WORDS-1:0][COEF_W-1:0]     word6_t;
  typedef logic [2*MAT_WORDS-1:0][2*COEF_W-1:0] prod_t;

  localparam word6_t MAT_IDENTITY = {32'd0, 32'd0, Q16_ONE, 32'd0, 32'd0, Q16_ONE};

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic signed [COEF_W-1:0] shift_x;
    logic signed [COEF_W-1:0] shift_y;
    logic signed [COEF_W-1:0] point_x;
    logic signed [COEF_W-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [2:0]                status;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    word6_t                    mat;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic                      sat;
  } fin_t;

endpackage

FILE: design/amst_stack_mem.sv
// Matrix stack memory: one saved matrix per row, registered read.
module amst_stack_mem #(
  parameter int LEVELS = amst_pkg::STACK_LEVELS_DEF,
  localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  amst_pkg::word6_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output amst_pkg::word6_t rdata_r
);
  import amst_pkg::*;

  word6_t mem [LEVELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: design/amst_mac_array.sv
// Product array: twelve registered 32x32 signed products against the current matrix.
module amst_mac_array (
  input  logic             clk,
  input  logic             en,
  input  amst_pkg::word6_t op_u,
  input  amst_pkg::word6_t op_v,
  input  amst_pkg::word6_t mat,
  output amst_pkg::prod_t  prod_r
);
  import amst_pkg::*;

  prod_t prod_nxt;

  always_comb begin
    for (int i = 0; i < MAT_WORDS; i++) begin
      prod_nxt[2*i]   = 64'($signed(op_u[i]) * $signed(mat[i % 2]));
      prod_nxt[2*i+1] = 64'($signed(op_v[i]) * $signed(mat[2 + (i % 2)]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

FILE: design/amst_finish.sv
// Sum, shift and saturation of the products into a new matrix and a vertex.
module amst_finish (
  input  amst_pkg::prod_t    prod,
  input  amst_pkg::word6_t   mat,
  input  logic signed [15:0] ofs_x,
  input  logic signed [15:0] ofs_y,
  output amst_pkg::fin_t     fin
);
  import amst_pkg::*;

  logic [MAT_WORDS-1:0][65:0] tot;
  logic [16:0]                cx;
  logic [16:0]                cy;

  function automatic logic [31:0] sat32(input logic [49:0] h);
    logic [31:0] r;
    if (&h[49:31] || ~|h[49:31]) begin
      r = h[31:0];
    end else if (h[49]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [16:0] to_coord(input logic [65:0] t, input logic [15:0] off);
    logic [33:0] q;
    logic        inc;
    logic [35:0] w;
    logic [16:0] r;
    q   = t[65:32];
    inc = t[65] & (|t[31:0]);
    w   = {{2{q[33]}}, q} + {35'd0, inc} + {{20{off[15]}}, off};
    if (&w[35:15] || ~|w[35:15]) begin
      r = {1'b0, w[15:0]};
    end else if (w[35]) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b1, 16'h7FFF};
    end
    return r;
  endfunction

  always_comb begin
    fin = '0;
    for (int i = 0; i < MAT_WORDS; i++) begin
      tot[i] = {{2{prod[2*i][63]}}, prod[2*i]}
             + {{2{prod[2*i+1][63]}}, prod[2*i+1]}
             + ((i >= 4) ? {{18{mat[i][31]}}, mat[i], 16'd0} : 66'd0);
      fin.mat[i] = sat32(tot[i][65:16]);
    end
    cx      = to_coord(tot[4], ofs_x);
    cy      = to_coord(tot[5], ofs_y);
    fin.vx  = cx[15:0];
    fin.vy  = cy[15:0];
    fin.sat = cx[16] | cy[16];
  end

endmodule

FILE: design/affine_matrix_stack_transform.sv
// Top level of the affine vertex front end with matrix stack.
//
// Input channel in_valid / in_stall / in_item carries one operation per
// transaction: push, pop, multiply, begin shape or vertex. Every transaction
// produces exactly one result on out_valid / out_stall / out_item.
// The cfg_we / cfg_index / cfg_wdata port sets the origin offsets; write it
// only while no transaction is in flight.
// A result passes from the input register through the product array and
// the finish and update stage into the output register. Begin shape and
// vertex let the next item follow straight behind; push, pop and multiply
// hold the next item back until they complete, since its products need the
// matrix, stack depth and stack memory row they leave behind.
// Reset: identity matrix, empty stack, offsets zero, no shape open,
// pipeline empty. The stack memory itself is not cleared.
// Receiver stall: the output register holds its transaction, the two
// internal stages fill, then in_stall rises.
module affine_matrix_stack_transform #(
  parameter int STACK_LEVELS = amst_pkg::STACK_LEVELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  amst_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output amst_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [amst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [amst_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import amst_pkg::*;

  localparam int AW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
  localparam int DW = $clog2(STACK_LEVELS + 1);

  logic               s1_valid_r;
  in_item_t           s1_item_r;
  logic               s2_valid_r;
  logic [2:0]         s2_kind_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  word6_t             mat_r, mat_nxt;
  logic [DW-1:0]      depth_r, depth_nxt;
  logic               has_vtx_r, has_vtx_nxt;
  logic signed [15:0] last_x_r, last_x_nxt;
  logic signed [15:0] last_y_r, last_y_nxt;
  logic signed [15:0] ofs_x_r;
  logic signed [15:0] ofs_y_r;

  word6_t             op_u;
  word6_t             op_v;
  prod_t              s2_prod;
  word6_t             pop_mat;
  fin_t               fin;
  out_item_t          res;

  logic               s2_done;
  logic               s2_blocks;
  logic               s1_adv;
  logic               mem_we;
  logic [DW-1:0]      depth_dec;
  logic [AW-1:0]      mem_raddr;
  logic [AW-1:0]      mem_waddr;

  assign s2_done   = s2_valid_r && (!out_valid_r || !out_stall);
  assign s2_blocks = (s2_kind_r == KIND_PUSH) || (s2_kind_r == KIND_POP) ||
                     (s2_kind_r == KIND_MUL);
  assign s1_adv    = s1_valid_r && (!s2_valid_r || (s2_done && !s2_blocks));
  assign in_stall  = s1_valid_r && !s1_adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign depth_dec = depth_r - DW'(1);
  assign mem_raddr = depth_dec[AW-1:0];
  assign mem_waddr = depth_r[AW-1:0];

  always_comb begin
    op_u[0] = s1_item_r.coef_a;
    op_v[0] = s1_item_r.coef_b;
    op_u[1] = s1_item_r.coef_a;
    op_v[1] = s1_item_r.coef_b;
    op_u[2] = s1_item_r.coef_c;
    op_v[2] = s1_item_r.coef_d;
    op_u[3] = s1_item_r.coef_c;
    op_v[3] = s1_item_r.coef_d;
    if (s1_item_r.kind == KIND_VERTEX) begin
      op_u[4] = s1_item_r.point_x;
      op_v[4] = s1_item_r.point_y;
      op_u[5] = s1_item_r.point_x;
      op_v[5] = s1_item_r.point_y;
    end else begin
      op_u[4] = s1_item_r.shift_x;
      op_v[4] = s1_item_r.shift_y;
      op_u[5] = s1_item_r.shift_x;
      op_v[5] = s1_item_r.shift_y;
    end
  end

  amst_mac_array u_mac (
    .clk    (clk),
    .en     (s1_adv),
    .op_u   (op_u),
    .op_v   (op_v),
    .mat    (mat_r),
    .prod_r (s2_prod)
  );

  amst_stack_mem #(
    .LEVELS (STACK_LEVELS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mat_r),
    .re      (s1_adv),
    .raddr   (mem_raddr),
    .rdata_r (pop_mat)
  );

  amst_finish u_fin (
    .prod  (s2_prod),
    .mat   (mat_r),
    .ofs_x (ofs_x_r),
    .ofs_y (ofs_y_r),
    .fin   (fin)
  );

  always_comb begin
    mat_nxt     = mat_r;
    depth_nxt   = depth_r;
    has_vtx_nxt = has_vtx_r;
    last_x_nxt  = last_x_r;
    last_y_nxt  = last_y_r;
    mem_we      = 1'b0;
    res         = '0;
    res.status  = ST_DONE;
    case (s2_kind_r)
      KIND_PUSH: begin
        if (depth_r >= DW'(STACK_LEVELS)) begin
          res.status = ST_OVERFLOW;
        end else begin
          mem_we    = s2_done;
          depth_nxt = depth_r + DW'(1);
        end
      end
      KIND_POP: begin
        if (depth_r == '0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          depth_nxt = depth_dec;
          mat_nxt   = pop_mat;
        end
      end
      KIND_MUL: begin
        mat_nxt = fin.mat;
      end
      KIND_BEGIN: begin
        has_vtx_nxt = 1'b0;
      end
      KIND_VERTEX: begin
        res.out_x     = fin.vx;
        res.out_y     = fin.vy;
        res.saturated = fin.sat;
        if (has_vtx_r && (fin.vx == last_x_r) && (fin.vy == last_y_r)) begin
          res.status = ST_DUPLICATE;
        end else begin
          res.status  = ST_APPENDED;
          last_x_nxt  = fin.vx;
          last_y_nxt  = fin.vy;
          has_vtx_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mat_r       <= MAT_IDENTITY;
      depth_r     <= '0;
      has_vtx_r   <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      ofs_x_r     <= '0;
      ofs_y_r     <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_done) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_done) begin
        out_valid_r <= 1'b1;
        mat_r       <= mat_nxt;
        depth_r     <= depth_nxt;
        has_vtx_r   <= has_vtx_nxt;
        last_x_r    <= last_x_nxt;
        last_y_r    <= last_y_nxt;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X: ofs_x_r <= cfg_wdata;
          CFG_ORIGIN_Y: ofs_y_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      s2_kind_r <= s1_item_r.kind;
    end
    if (s2_done) begin
      out_item_r <= res;
    end
  end

endmodule

FILE: design/amst_checker.sv
// Port-level checker for the affine matrix stack transform, with its bind.
module amst_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input amst_pkg::in_item_t              in_item,
  input logic                            out_valid,
  input logic                            out_stall,
  input amst_pkg::out_item_t             out_item
);
  import amst_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_non_vertex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_APPENDED) && (out_item.status != ST_DUPLICATE)
      |-> (out_item.out_x == 16'sd0) && (out_item.out_y == 16'sd0) && !out_item.saturated)
    else $error("non-vertex result carries coordinates");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated
      |-> (out_item.out_x == 16'sh7FFF) || (out_item.out_x == 16'sh8000) ||
          (out_item.out_y == 16'sh7FFF) || (out_item.out_y == 16'sh8000))
    else $error("saturated flag without a clamped coordinate");

endmodule

bind affine_matrix_stack_transform amst_checker u_amst_checker (.*);
